// File: hdl/gbc_pkg.sv
// Package for the gyro bias calibration and motion detection block.
// Holds shared constants, types and the saturating-add and constant-divide helpers.
// No dependencies.
package gbc_pkg;

  // Calibration schedule
  localparam int SAMPLES_PER_GROUP = 10;
  localparam int NUM_GROUPS        = 10;

  // Field widths
  localparam int SAMPLE_W  = 16;
  localparam int OFS_W     = 32;
  localparam int FRAC_BITS = 8;
  localparam int THRESH_W  = 15;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(100);

  // Counter widths
  localparam int SIDX_W = $clog2(SAMPLES_PER_GROUP);
  localparam int GIDX_W = $clog2(NUM_GROUPS + 1);

  localparam logic [SIDX_W-1:0] SIDX_LAST = SIDX_W'(SAMPLES_PER_GROUP - 1);
  localparam logic [GIDX_W-1:0] GIDX_LAST = GIDX_W'(NUM_GROUPS - 1);

  // Divide by 10 (first group) or 11 (later groups) via reciprocal multiply.
  // recip = ceil(2^35 / d); exact floor for magnitudes up to 2^31.
  localparam int              RECIP_SHIFT = 35;
  localparam logic [31:0]     FIRST_RECIP = 32'd3435973837;
  localparam logic [31:0]     LATER_RECIP = 32'd3123612579;

  // Offsets handed from calibration to detection
  typedef struct packed {
    logic                    active;
    logic signed [OFS_W-1:0] x;
    logic signed [OFS_W-1:0] y;
    logic signed [OFS_W-1:0] z;
  } ofs_t;

  // One result item
  typedef struct packed {
    logic motion;
    logic led;
    logic calibrating;
    logic pending;
  } res_t;

  // Offset plus sample scaled to fixed point, saturated to OFS_W bits
  function automatic logic signed [OFS_W-1:0] sat_add(
    input logic signed [OFS_W-1:0]    ofs,
    input logic signed [SAMPLE_W-1:0] smp
  );
    logic signed [OFS_W:0] sum;
    sum = (OFS_W+1)'(ofs) + (OFS_W+1)'(signed'({smp, {FRAC_BITS{1'b0}}}));
    if (sum[OFS_W] != sum[OFS_W-1]) begin
      sat_add = sum[OFS_W] ? {1'b1, {(OFS_W-1){1'b0}}} : {1'b0, {(OFS_W-1){1'b1}}};
    end else begin
      sat_add = sum[OFS_W-1:0];
    end
  endfunction

  // Signed divide by 10 or 11, truncating toward zero
  function automatic logic signed [OFS_W-1:0] div_const(
    input logic signed [OFS_W-1:0] n,
    input logic                    later
  );
    logic [OFS_W-1:0] mag;
    logic [31:0]      recip;
    logic [63:0]      prod;
    logic [OFS_W-1:0] quo;
    mag   = n[OFS_W-1] ? (~n + 1'b1) : n;
    recip = later ? LATER_RECIP : FIRST_RECIP;
    prod  = {32'b0, mag} * {32'b0, recip};
    quo   = OFS_W'(prod[63:RECIP_SHIFT]);
    div_const = n[OFS_W-1] ? (~quo + 1'b1) : quo;
  endfunction

endpackage

// File: hdl/gyro_bias_calib_motion_detect.sv
// Top level: input register, calibration and detection, result register.
// Depends on gbc_pkg, gbc_calib, gbc_detect.
// An input transfer passes through the input reg and then the result reg on its
// way to the earliest result transfer. Throughput: one sample per cycle; the input stalls
// only while a held result is blocked by out_stall_i.
// Reset (rst_ni, async, active low) clears offsets and counters, starts
// calibration and sets the threshold to 100; no clearing pass is needed.
module gyro_bias_calib_motion_detect (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0] gyro_x_i,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0] gyro_y_i,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0] gyro_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                motion_o,
  output logic                                led_o,
  output logic                                calibrating_o,
  output logic                                confirm_pending_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gbc_pkg::THRESH_W-1:0]        cfg_data_i
);

  logic                                s1_valid_q;
  logic signed [gbc_pkg::SAMPLE_W-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic                                out_valid_q;
  gbc_pkg::res_t                       out_res_q;
  gbc_pkg::ofs_t                       ofs;
  gbc_pkg::res_t                       res;
  logic                                out_open, fire, in_take;

  // Handshake: result register frees when empty or taken
  assign out_open    = !out_valid_q || !out_stall_i;
  assign fire        = s1_valid_q && out_open;
  assign in_stall_o  = s1_valid_q && !out_open;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_x_q <= gyro_x_i;
      s1_y_q <= gyro_y_i;
      s1_z_q <= gyro_z_i;
    end
  end

  gbc_calib u_calib (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (fire),
    .gyro_x_i (s1_x_q),
    .gyro_y_i (s1_y_q),
    .gyro_z_i (s1_z_q),
    .ofs_o    (ofs)
  );

  gbc_detect u_detect (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .step_i     (fire),
    .gyro_x_i   (s1_x_q),
    .gyro_y_i   (s1_y_q),
    .gyro_z_i   (s1_z_q),
    .ofs_i      (ofs),
    .res_o      (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_open) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign motion_o          = out_res_q.motion;
  assign led_o             = out_res_q.led;
  assign calibrating_o     = out_res_q.calibrating;
  assign confirm_pending_o = out_res_q.pending;

  // Stall only with a sample held and the result side blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without cause");

  // A calibration result carries no detection flags
  a_calib_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && calibrating_o) |-> (!motion_o && !confirm_pending_o))
    else $error("detection flag during calibration");

  // Confirmed motion always lights the LED, and never with an arm
  a_motion_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && motion_o) |-> (led_o && !confirm_pending_o))
    else $error("motion without LED or with arm");

endmodule

// File: hdl/gbc_calib.sv
// Offset calibration: per-axis accumulate and group divide, group counters.
// Depends on gbc_pkg.
module gbc_calib (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0] gyro_x_i,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0] gyro_y_i,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0] gyro_z_i,
  output gbc_pkg::ofs_t                       ofs_o
);

  logic signed [gbc_pkg::OFS_W-1:0] ofs_x_q, ofs_y_q, ofs_z_q;
  logic signed [gbc_pkg::OFS_W-1:0] ofs_x_d, ofs_y_d, ofs_z_d;
  logic signed [gbc_pkg::OFS_W-1:0] sum_x, sum_y, sum_z;
  logic [gbc_pkg::SIDX_W-1:0]       sidx_q, sidx_d;
  logic [gbc_pkg::GIDX_W-1:0]       gidx_q, gidx_d;
  logic                             active_q, active_d;
  logic                             grp_end, later;

  // Accumulate, then divide at the end of a group
  always_comb begin
    sum_x   = gbc_pkg::sat_add(ofs_x_q, gyro_x_i);
    sum_y   = gbc_pkg::sat_add(ofs_y_q, gyro_y_i);
    sum_z   = gbc_pkg::sat_add(ofs_z_q, gyro_z_i);
    grp_end = (sidx_q == gbc_pkg::SIDX_LAST);
    later   = (gidx_q != '0);
    ofs_x_d = ofs_x_q;
    ofs_y_d = ofs_y_q;
    ofs_z_d = ofs_z_q;
    sidx_d  = sidx_q;
    gidx_d  = gidx_q;
    active_d = active_q;
    if (step_i && active_q) begin
      if (grp_end) begin
        ofs_x_d = gbc_pkg::div_const(sum_x, later);
        ofs_y_d = gbc_pkg::div_const(sum_y, later);
        ofs_z_d = gbc_pkg::div_const(sum_z, later);
        sidx_d  = '0;
        gidx_d  = gidx_q + 1'b1;
        if (gidx_q == gbc_pkg::GIDX_LAST) begin
          active_d = 1'b0;
        end
      end else begin
        ofs_x_d = sum_x;
        ofs_y_d = sum_y;
        ofs_z_d = sum_z;
        sidx_d  = sidx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_x_q  <= '0;
      ofs_y_q  <= '0;
      ofs_z_q  <= '0;
      sidx_q   <= '0;
      gidx_q   <= '0;
      active_q <= 1'b1;
    end else begin
      ofs_x_q  <= ofs_x_d;
      ofs_y_q  <= ofs_y_d;
      ofs_z_q  <= ofs_z_d;
      sidx_q   <= sidx_d;
      gidx_q   <= gidx_d;
      active_q <= active_d;
    end
  end

  assign ofs_o.active = active_q;
  assign ofs_o.x      = ofs_x_q;
  assign ofs_o.y      = ofs_y_q;
  assign ofs_o.z      = ofs_z_q;

  // Calibration never restarts once finished
  a_active_stays_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |=> !active_q) else $error("calibration restarted");

  // Offsets frozen during detection
  a_ofs_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |=> ($stable(ofs_x_q) && $stable(ofs_y_q) && $stable(ofs_z_q)))
    else $error("offset changed after calibration");

  // Sample counter stays inside a group
  a_sidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sidx_q <= gbc_pkg::SIDX_LAST) else $error("sample index out of range");

endmodule

// File: hdl/gbc_detect.sv
// Motion detection: per-axis threshold compare, two-sample confirm, LED level.
// Holds the threshold register. Depends on gbc_pkg.
module gbc_detect (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gbc_pkg::THRESH_W-1:0]        cfg_data_i,
  input  logic                                step_i,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0] gyro_x_i,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0] gyro_y_i,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0] gyro_z_i,
  input  gbc_pkg::ofs_t                       ofs_i,
  output gbc_pkg::res_t                       res_o
);

  localparam int DEV_W = gbc_pkg::OFS_W + 2;

  logic [gbc_pkg::THRESH_W-1:0] thresh_q;
  logic                         armed_q, armed_d;
  logic                         led_q, led_d;
  logic signed [DEV_W-1:0]      limit;
  logic                         hit;

  // Deviation of sample above offset, both in fixed point
  function automatic logic exceeds(
    input logic signed [gbc_pkg::SAMPLE_W-1:0] smp,
    input logic signed [gbc_pkg::OFS_W-1:0]    ofs,
    input logic signed [DEV_W-1:0]             lim
  );
    logic signed [DEV_W-1:0] dev;
    dev = DEV_W'(signed'({smp, {gbc_pkg::FRAC_BITS{1'b0}}})) - DEV_W'(ofs);
    exceeds = (dev > lim);
  endfunction

  assign limit = DEV_W'(signed'({1'b0, thresh_q, {gbc_pkg::FRAC_BITS{1'b0}}}));
  assign hit   = exceeds(gyro_x_i, ofs_i.x, limit) ||
                 exceeds(gyro_y_i, ofs_i.y, limit) ||
                 exceeds(gyro_z_i, ofs_i.z, limit);

  // Confirmation state and result fields
  always_comb begin
    armed_d           = armed_q;
    led_d             = led_q;
    res_o.motion      = 1'b0;
    res_o.pending     = 1'b0;
    res_o.calibrating = ofs_i.active;
    if (!ofs_i.active) begin
      if (armed_q) begin
        armed_d = 1'b0;
        if (hit) begin
          res_o.motion = 1'b1;
          led_d        = 1'b1;
        end
      end else if (hit) begin
        armed_d       = 1'b1;
        res_o.pending = 1'b1;
      end else begin
        led_d = 1'b0;
      end
    end
    res_o.led = led_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      led_q   <= 1'b0;
    end else if (step_i) begin
      armed_q <= armed_d;
      led_q   <= led_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= gbc_pkg::THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_data_i;
    end
  end

endmodule

// File: tb/gyro_bias_calib_motion_detect_test.sv
// Self-checking testbench for gyro_bias_calib_motion_detect: sends gyro samples with random
// gaps and back-pressure, and checks each result against an in-bench bias and motion tracker.
// Depends on gbc_pkg and the RTL of the block only.
module gyro_bias_calib_motion_detect_test;

  localparam int SAMPLE_W          = gbc_pkg::SAMPLE_W;
  localparam int OFS_W             = gbc_pkg::OFS_W;
  localparam int THRESH_W          = gbc_pkg::THRESH_W;
  localparam int SAMPLES_PER_GROUP = gbc_pkg::SAMPLES_PER_GROUP;
  localparam int NUM_GROUPS        = gbc_pkg::NUM_GROUPS;
  localparam logic [THRESH_W-1:0] THRESH_RESET = gbc_pkg::THRESH_RESET;

  typedef gbc_pkg::res_t res_t;

  localparam int PHASE_ITEMS  = 205;
  localparam int HOLD_AT      = 250;   // results seen before the long output hold-off
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_LIMIT   = 1000;  // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES = 8;
  localparam int FIRST_DIVISOR = 10;
  localparam int LATER_DIVISOR = 11;
  localparam longint OFS_MAX = (longint'(1) <<< 31) - 1;
  localparam longint OFS_MIN = -(longint'(1) <<< 31);
  localparam longint SAMPLE_MAX = 32767;
  localparam longint SAMPLE_MIN = -32768;

  typedef enum int {GAPS_NONE, GAPS_SHORT, GAPS_MIXED} gap_mode_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x, y, z;
  } triple_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x, y, z;
    logic [7:0]                 reps;
    logic                       typed;
    res_t                       res;
  } stim_row_t;

  localparam res_t CALIB_RES = '{motion: 1'b0, led: 1'b0, calibrating: 1'b1, pending: 1'b0};

  logic                       clk = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] gyro_x_i = '0;
  logic signed [SAMPLE_W-1:0] gyro_y_i = '0;
  logic signed [SAMPLE_W-1:0] gyro_z_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       motion_o;
  logic                       led_o;
  logic                       calibrating_o;
  logic                       confirm_pending_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [THRESH_W-1:0]        cfg_data_i = '0;

  // Tracker state: offsets, counters, arm and LED, threshold
  logic signed [OFS_W-1:0] ofs_m [3];
  int                      grp_m;
  int                      smp_m;
  logic                    calib_m;
  logic                    armed_m;
  logic                    led_m;
  logic [THRESH_W-1:0]     thresh_m;

  res_t      flags_due [$];
  gap_mode_e idle_mode = GAPS_SHORT;
  int        results_seen = 0;
  int        stall_left = 0;
  bit        hold_done = 1'b0;
  bit        failed = 1'b0;

  gyro_bias_calib_motion_detect uut (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .gyro_x_i          (gyro_x_i),
    .gyro_y_i          (gyro_y_i),
    .gyro_z_i          (gyro_z_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .motion_o          (motion_o),
    .led_o             (led_o),
    .calibrating_o     (calibrating_o),
    .confirm_pending_o (confirm_pending_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the tracker by one accepted sample and return the flags it yields
  function automatic res_t track_sample(input logic signed [SAMPLE_W-1:0] sx, sy, sz);
    longint smp [3];
    longint acc;
    res_t   r;
    bit     hit;
    smp[0] = sx;
    smp[1] = sy;
    smp[2] = sz;
    r = '0;
    hit = 1'b0;
    if (calib_m) begin
      r.calibrating = 1'b1;
      for (int a = 0; a < 3; a++) begin
        acc = longint'(ofs_m[a]) + smp[a] * 256;
        if (acc > OFS_MAX) acc = OFS_MAX;
        else if (acc < OFS_MIN) acc = OFS_MIN;
        ofs_m[a] = acc[OFS_W-1:0];
      end
      smp_m++;
      // group done: average down, divisor 10 first, 11 after
      if (smp_m >= SAMPLES_PER_GROUP) begin
        for (int a = 0; a < 3; a++) begin
          acc = longint'(ofs_m[a]) / ((grp_m == 0) ? FIRST_DIVISOR : LATER_DIVISOR);
          ofs_m[a] = acc[OFS_W-1:0];
        end
        smp_m = 0;
        grp_m++;
        if (grp_m >= NUM_GROUPS) calib_m = 1'b0;
      end
    end else begin
      // one-sided deviation test per axis
      for (int a = 0; a < 3; a++) begin
        if (smp[a] * 256 - longint'(ofs_m[a]) > longint'(thresh_m) * 256) hit = 1'b1;
      end
      if (armed_m) begin
        armed_m = 1'b0;
        if (hit) begin
          r.motion = 1'b1;
          led_m = 1'b1;
        end
      end else if (hit) begin
        armed_m = 1'b1;
        r.pending = 1'b1;
      end else begin
        led_m = 1'b0;
      end
    end
    r.led = led_m;
    return r;
  endfunction

  // Largest sample on an axis that still counts as quiet
  function automatic longint quiet_top(input logic signed [OFS_W-1:0] ofs);
    return (longint'(ofs) + longint'(thresh_m) * 256) >>> 8;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input longint v);
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    else if (v < SAMPLE_MIN) v = SAMPLE_MIN;
    return v[SAMPLE_W-1:0];
  endfunction

  // Mix of quiet, near-threshold, exceeding and fully random samples
  function automatic triple_t random_sample();
    longint  v [3];
    longint  top;
    int      kind;
    int      pick;
    triple_t t;
    kind = $urandom_range(0, 9);
    pick = $urandom_range(0, 2);
    for (int a = 0; a < 3; a++) begin
      top = quiet_top(ofs_m[a]);
      if (kind <= 2) v[a] = top - int'($urandom_range(0, 600));
      else if (kind <= 5) v[a] = top + int'($urandom_range(0, 3)) - 1;
      else if (kind <= 7 && a == pick) v[a] = top + 1 + int'($urandom_range(0, 3000));
      else v[a] = $signed(SAMPLE_W'($urandom));
    end
    t.x = clamp_sample(v[0]);
    t.y = clamp_sample(v[1]);
    t.z = clamp_sample(v[2]);
    return t;
  endfunction

  // Idle length in cycles: mostly none, short ones, and a few long in mixed mode
  function automatic int draw_gap();
    if (idle_mode == GAPS_NONE || $urandom_range(0, 99) < 70) return 0;
    if (idle_mode == GAPS_MIXED && $urandom_range(0, 9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // One input transfer; payload holds while stalled
  task automatic send_sample(input triple_t smp, input bit typed, input res_t typed_res);
    int   gap;
    res_t r;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid_i <= 1'b1;
    gyro_x_i <= smp.x;
    gyro_y_i <= smp.y;
    gyro_z_i <= smp.z;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    r = track_sample(smp.x, smp.y, smp.z);
    flags_due.push_back(typed ? typed_res : r);
  endtask

  // Threshold write, only once every outstanding result has come back
  task automatic write_threshold(input logic [THRESH_W-1:0] level);
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (flags_due.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= level;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    thresh_m = level;
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  // Output back-pressure, with one long hold-off to fill the pipeline
  always @(negedge clk) begin
    if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = draw_gap();
    end
  end

  // Compare each result transfer with the oldest expected flags
  always @(posedge clk) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (flags_due.size() == 0) begin
        $error("result transfer with no sample outstanding");
        failed = 1'b1;
      end else begin
        want = flags_due.pop_front();
        if (motion_o !== want.motion) begin
          $error("motion: expected %0b, got %0b", want.motion, motion_o);
          failed = 1'b1;
        end
        if (led_o !== want.led) begin
          $error("led: expected %0b, got %0b", want.led, led_o);
          failed = 1'b1;
        end
        if (calibrating_o !== want.calibrating) begin
          $error("calibrating: expected %0b, got %0b", want.calibrating, calibrating_o);
          failed = 1'b1;
        end
        if (confirm_pending_o !== want.pending) begin
          $error("confirm_pending: expected %0b, got %0b", want.pending, confirm_pending_o);
          failed = 1'b1;
        end
      end
      results_seen++;
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    stim_row_t           rows [19];
    logic [THRESH_W-1:0] levels [8];
    triple_t             smp;

    for (int a = 0; a < 3; a++) ofs_m[a] = '0;
    grp_m = 0;
    smp_m = 0;
    calib_m = 1'b1;
    armed_m = 1'b0;
    led_m = 1'b0;
    thresh_m = THRESH_RESET;

    // Calibration rows carry extremes and alternating bit patterns, then fillers
    // that leave fractional offsets; detection rows walk every arm/confirm case.
    rows = '{
      '{32767, -32768, 0, 1, 1'b1, CALIB_RES},
      '{-32768, 32767, -1, 1, 1'b1, CALIB_RES},
      '{-1, 0, 32767, 1, 1'b1, CALIB_RES},
      '{0, -1, -32768, 1, 1'b1, CALIB_RES},
      '{21845, -21846, 85, 1, 1'b1, CALIB_RES},
      '{-21846, 21845, -86, 1, 1'b1, CALIB_RES},
      '{123, -457, 7, 44, 1'b1, CALIB_RES},
      '{-5, 3, 2001, 50, 1'b1, CALIB_RES},
      '{0, 0, 0, 1, 1'b0, '0},                  // quiet, not armed
      '{32767, -32768, -32768, 1, 1'b0, '0},    // x exceeds: arm
      '{-32768, -32768, 32767, 1, 1'b0, '0},    // z exceeds: confirm, LED on
      '{-32768, 32767, -32768, 1, 1'b0, '0},    // y exceeds: arm
      '{-32768, -32768, -32768, 1, 1'b0, '0},   // armed but quiet: LED held
      '{-32768, -32768, -32768, 1, 1'b0, '0},   // quiet: LED off
      '{32767, 32767, 32767, 1, 1'b0, '0},
      '{0, 0, 0, 1, 1'b0, '0},
      '{32767, 32767, 32767, 1, 1'b0, '0},
      '{32767, 32767, 32767, 1, 1'b0, '0},
      '{32767, 32767, 32767, 1, 1'b0, '0}       // re-arm right after motion
    };
    levels = '{15'd0, 15'h7FFF, 15'd1, THRESH_W'($urandom_range(2, 32766)), 15'h5555,
               15'h2AAA, THRESH_W'($urandom_range(0, 400)), THRESH_RESET};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      smp = '{rows[i].x, rows[i].y, rows[i].z};
      repeat (rows[i].reps) send_sample(smp, rows[i].typed, rows[i].res);
    end

    foreach (levels[p]) begin
      write_threshold(levels[p]);
      idle_mode = gap_mode_e'(p % 3);
      repeat (PHASE_ITEMS) send_sample(random_sample(), 1'b0, '0);
    end

    @(negedge clk);
    in_valid_i <= 1'b0;
    while (flags_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
